// File: hdl/dsb_pkg.sv
// Shared constants, types and a helper function for the bitmap deduplicating sorter.
`timescale 1ns / 1ps
`default_nettype none

package dsb_pkg;

    // Default number of map entries.
    localparam int MAP_SIZE_DEF = 1024;

    // Width of the value field; only values below 1 << VALUE_W can ever be marked.
    localparam int VALUE_W    = 10;
    localparam int VALUE_SPAN = 1 << VALUE_W;

    // The map is stored as words of 64 presence bits.
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // Update of one summary bit after a word has been written back.
    typedef struct packed {
        logic en;
        logic nonzero;
    } sum_upd_t;

    // Position of the lowest set bit of a word, found by halving the word six times.
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] rest;
        logic [BIT_W-1:0]  idx;
        int                half;
        rest = w;
        idx  = '0;
        for (int lvl = BIT_W - 1; lvl >= 0; lvl--)
        begin
            half = 1 << lvl;
            if ((rest & ((WORD_W'(1) << half) - WORD_W'(1))) == '0)
            begin
                idx[lvl] = 1'b1;
                rest     = rest >> half;
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: hdl/dsb_word_ram.sv
// Single-port-write, single-port-read synchronous memory holding the presence words.
`timescale 1ns / 1ps
`default_nettype none

module dsb_word_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [dsb_pkg::WORD_W-1:0]  wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output logic      [dsb_pkg::WORD_W-1:0]  rdata
);

    logic [dsb_pkg::WORD_W-1:0] mem [DEPTH];
    logic [dsb_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/dsb_summary.sv
// Summary bits marking which presence words are nonzero, with a first-set search.
`timescale 1ns / 1ps
`default_nettype none

module dsb_summary #(
    parameter int WORDS = 16,
    parameter int AW    = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dsb_pkg::sum_upd_t upd,
    input  wire logic [AW-1:0]     upd_idx,
    input  wire logic [AW-1:0]     chk_idx,
    output logic                   any,
    output logic      [AW-1:0]     first_idx,
    output logic                   chk_nz
);

    // A clear summary bit also means the memory word has not been written
    // since reset or was drained, so its content is taken as zero.
    logic [WORDS-1:0] nz_reg;
    logic [WORDS-1:0] nz_next;

    always_comb
    begin
        nz_next = nz_reg;
        if (upd.en)
        begin
            nz_next[upd_idx] = upd.nonzero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg <= '0;
        end
        else
        begin
            nz_reg <= nz_next;
        end
    end

    always_comb
    begin
        first_idx = '0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (nz_reg[i])
            begin
                first_idx = AW'(i);
            end
        end
    end

    assign any    = |nz_reg;
    assign chk_nz = nz_reg[chk_idx];

endmodule

`default_nettype wire

// File: hdl/dedup_sort_bitmap.sv
// Top level of the deduplicating bitmap sorter: command sequencer and result registers.
//
//  Channel  | Ports                          | Beat taken when
//  ---------+--------------------------------+------------------------------
//  command  | start, busy, cmd, value        | rising edge with start=1, busy=0
//  result   | done, result_value, found,last | rising edge ending the done cycle
//
// An insert inside the map or a pop on a nonempty map does a read-modify-write:
// the accept edge issues one read of the presence-word memory, and the next edge
// modifies that word and writes it back, so busy is high between those edges.
// An insert beyond the map or a pop on an empty map needs no memory access and
// leaves busy low throughout. Either way the result beat appears in the cycle
// after the command's last edge, while a new command may already be
// accepted. Reset clears the summary bits, which stand in for the whole map,
// so no clearing pass is needed. The receiver cannot stall: each result beat
// is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module dedup_sort_bitmap #(
    parameter int MAP_SIZE = dsb_pkg::MAP_SIZE_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         cmd,
    input  wire logic [dsb_pkg::VALUE_W-1:0]  value,
    output logic                              done,
    output logic      [dsb_pkg::VALUE_W-1:0]  result_value,
    output logic                              found,
    output logic                              last
);

    // Only values that fit the value field can ever be set, so the stored
    // map never needs more entries than that field can reach.
    localparam int EFF_SIZE = (MAP_SIZE < dsb_pkg::VALUE_SPAN) ? MAP_SIZE : dsb_pkg::VALUE_SPAN;
    localparam int WORDS    = (EFF_SIZE + dsb_pkg::WORD_W - 1) / dsb_pkg::WORD_W;
    localparam int WADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W    = $clog2(EFF_SIZE + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RMW
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic                         cmd_reg;
    logic [WADDR_W-1:0]           addr_reg;
    logic [dsb_pkg::BIT_W-1:0]    bit_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         done_reg;
    logic                         done_next;
    logic [dsb_pkg::VALUE_W-1:0]  result_reg;
    logic [dsb_pkg::VALUE_W-1:0]  result_next;
    logic                         found_reg;
    logic                         found_next;
    logic                         last_reg;
    logic                         last_next;

    logic                         accept;
    logic                         in_range;
    logic [WADDR_W-1:0]           rd_addr;

    logic                         ram_we;
    logic [dsb_pkg::WORD_W-1:0]   ram_wdata;
    logic [dsb_pkg::WORD_W-1:0]   ram_rdata;
    logic [dsb_pkg::WORD_W-1:0]   cur_word;
    logic [dsb_pkg::WORD_W-1:0]   new_word;
    logic [dsb_pkg::BIT_W-1:0]    low_bit;

    dsb_pkg::sum_upd_t            sum_upd;
    logic                         sum_any;
    logic [WADDR_W-1:0]           sum_first;
    logic                         sum_chk_nz;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(value) < MAP_SIZE);

    // Insert reads the word that holds the value; pop reads the first nonzero word.
    assign rd_addr = (cmd == dsb_pkg::CMD_POP) ? sum_first : value[dsb_pkg::BIT_W +: WADDR_W];

    dsb_word_ram #(
        .DEPTH (WORDS),
        .AW    (WADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    dsb_summary #(
        .WORDS (WORDS),
        .AW    (WADDR_W)
    ) u_summary (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (sum_upd),
        .upd_idx   (addr_reg),
        .chk_idx   (addr_reg),
        .any       (sum_any),
        .first_idx (sum_first),
        .chk_nz    (sum_chk_nz)
    );

    // A word whose summary bit is clear has never been filled since reset or
    // was drained; its memory content is stale and reads as zero.
    assign cur_word = sum_chk_nz ? ram_rdata : '0;
    assign low_bit  = dsb_pkg::lowest_bit(cur_word);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = '0;
        found_next  = 1'b0;
        last_next   = 1'b0;
        ram_we      = 1'b0;
        new_word    = cur_word;
        sum_upd     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // An out-of-range insert or a pop on an empty map needs no
                    // memory access and answers with an all-zero beat.
                    if ((cmd == dsb_pkg::CMD_INSERT && !in_range) ||
                        (cmd == dsb_pkg::CMD_POP && !sum_any))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_RMW;
                    end
                end
            end
            ST_RMW:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (cmd_reg == dsb_pkg::CMD_INSERT)
                begin
                    // A duplicate leaves word and count untouched.
                    new_word = cur_word | (dsb_pkg::WORD_W'(1) << bit_reg);
                    if (!cur_word[bit_reg])
                    begin
                        ram_we          = 1'b1;
                        sum_upd.en      = 1'b1;
                        sum_upd.nonzero = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    new_word        = cur_word & ~(dsb_pkg::WORD_W'(1) << low_bit);
                    ram_we          = 1'b1;
                    sum_upd.en      = 1'b1;
                    sum_upd.nonzero = (new_word != '0);
                    count_next      = count_reg - CNT_W'(1);
                    result_next     = dsb_pkg::VALUE_W'({addr_reg, low_bit});
                    found_next      = 1'b1;
                    last_next       = (count_reg == CNT_W'(1));
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_wdata = new_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            last_reg   <= 1'b0;
            result_reg <= '0;
            cmd_reg    <= dsb_pkg::CMD_INSERT;
            addr_reg   <= '0;
            bit_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            last_reg   <= last_next;
            result_reg <= result_next;
            if (accept)
            begin
                cmd_reg  <= cmd;
                addr_reg <= rd_addr;
                bit_reg  <= value[dsb_pkg::BIT_W-1:0];
            end
        end
    end

    assign done         = done_reg;
    assign result_value = result_reg;
    assign found        = found_reg;
    assign last         = last_reg;

    // The population count and the summary bits must agree on emptiness.
    a_count_matches_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == !sum_any)
        else $error("population count disagrees with summary bits");

    // A result beat follows either a read-modify-write or a command that needed none.
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_RMW || $past(accept)))
        else $error("result beat without a command");

    // A successful pop removes exactly one entry.
    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not decrement the population count");

    // The final entry leaves the map empty.
    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && last_reg) |-> (found_reg && !sum_any))
        else $error("last flagged while entries remain");

endmodule

`default_nettype wire
